@@ rtl/yzd_pkg.sv @@
// ----------------------------------------------------------------------------
// Yaz0 window decoder package
// Shared constants, command format and helpers for the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yzd_pkg;

  localparam int WINDOW_BYTES = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_BYTES);
  localparam int OUT_LANES    = 8;
  localparam int LANE_IW      = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int LANE_CW      = $clog2(OUT_LANES + 1);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] FLAG_MSB_MASK = 8'h80;
  localparam logic [3:0] DIST_HI_MASK  = 4'h0f;
  localparam logic [8:0] LONG_LEN_BASE = 9'h12;
  localparam logic [4:0] HEADER_BYTES  = 5'h10;

  // Configuration register indexes.
  localparam logic REG_SKIP_OFFSET = 1'b0;
  localparam logic REG_MAX_OUT     = 1'b1;

  typedef enum logic [1:0] {
    OP_LIT,
    OP_COPY,
    OP_HDR,
    OP_BAD
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  lit;
    logic [11:0] back_dist;
    logic [8:0]  len;
    logic [23:0] target;
  } cmd_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h59;  // 'Y'
      2'd1:    m = 8'h61;  // 'a'
      2'd2:    m = 8'h7a;  // 'z'
      default: m = 8'h30;  // '0'
    endcase
    return m;
  endfunction

endpackage

@@ rtl/yzd_stream_if.sv @@
// ----------------------------------------------------------------------------
// Yaz0 decoder stream interfaces
// Valid/ready channels for compressed input bytes and decoded output groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface yzd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, in_byte, stream_start, input ready);
  modport sink   (input valid, in_byte, stream_start, output ready);
endinterface

interface yzd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  byte_count;
  logic        is_last;
  logic        bad_magic;
  logic [23:0] total_emitted;

  modport source (output valid, out_data, byte_count, is_last, bad_magic, total_emitted,
                  input ready);
  modport sink   (input valid, out_data, byte_count, is_last, bad_magic, total_emitted,
                  output ready);
endinterface

@@ rtl/yzd_front.sv @@
// ----------------------------------------------------------------------------
// Yaz0 decoder front end
// Parses the header and flag/reference bytes into literal and copy commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yzd_front
  import yzd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  yzd_in_if.sink        in_i,
  input  logic [23:0]   skip_offset_i,
  input  logic [23:0]   max_out_i,
  input  logic          enable_i,
  input  logic          cmd_full_i,
  output logic          cmd_push_o,
  output cmd_t          cmd_o
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_FLAG    = 3'd1;
  localparam logic [2:0] PH_LITERAL = 3'd2;
  localparam logic [2:0] PH_REF1    = 3'd3;
  localparam logic [2:0] PH_REF2    = 3'd4;
  localparam logic [2:0] PH_REF3    = 3'd5;

  logic [2:0]  ph_q, ph_d;
  logic [4:0]  hidx_q, hidx_d;
  logic [31:0] dlen_q, dlen_d;
  logic [7:0]  flag_q, flag_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  rf_q, rf_d;
  logic [11:0] dist_q, dist_d;
  logic        stop_q, stop_d;

  logic        acc;
  logic [7:0]  b;

  assign in_i.ready = enable_i && !cmd_full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  always_comb begin
    logic [2:0]  ph_c;
    logic [4:0]  hidx_c;
    logic [31:0] dlen_c;
    logic        stop_c;
    logic [7:0]  fl_n;
    logic [3:0]  left_n;
    logic [2:0]  ph_n;
    logic [31:0] avail;

    ph_d       = ph_q;
    hidx_d     = hidx_q;
    dlen_d     = dlen_q;
    flag_d     = flag_q;
    left_d     = left_q;
    rf_d       = rf_q;
    dist_d     = dist_q;
    stop_d     = stop_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;

    ph_c   = in_i.stream_start ? PH_HEADER : ph_q;
    hidx_c = in_i.stream_start ? 5'd0 : hidx_q;
    dlen_c = in_i.stream_start ? 32'd0 : dlen_q;
    stop_c = in_i.stream_start ? 1'b0 : stop_q;

    // Advance to the next flag bit after a literal or a copy.
    fl_n   = {flag_q[6:0], 1'b0};
    left_n = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    if (left_n == 4'd0) begin
      ph_n = PH_FLAG;
    end else if ((fl_n & FLAG_MSB_MASK) != 8'd0) begin
      ph_n = PH_LITERAL;
    end else begin
      ph_n = PH_REF1;
    end

    avail = (dlen_c > {8'd0, skip_offset_i}) ? dlen_c - {8'd0, skip_offset_i} : 32'd0;

    if (acc) begin
      ph_d   = ph_c;
      hidx_d = hidx_c;
      dlen_d = dlen_c;
      stop_d = stop_c;
      if (!stop_c) begin
        case (ph_c)
          PH_HEADER: begin
            hidx_d = hidx_c + 5'd1;
            if (hidx_c < 5'd4) begin
              if (b != magic_byte(hidx_c[1:0])) begin
                cmd_push_o = 1'b1;
                cmd_o.op   = OP_BAD;
                stop_d     = 1'b1;
              end
            end else if (hidx_c < 5'd8) begin
              dlen_d = {dlen_c[23:0], b};
            end
            if (!(hidx_c < 5'd4 && b != magic_byte(hidx_c[1:0])) &&
                hidx_c == HEADER_BYTES - 5'd1) begin
              ph_d       = PH_FLAG;
              cmd_push_o = 1'b1;
              cmd_o.op   = OP_HDR;
              cmd_o.target = (avail < {8'd0, max_out_i}) ? avail[23:0] : max_out_i;
            end
          end
          PH_FLAG: begin
            flag_d = b;
            left_d = 4'd8;
            ph_d   = ((b & FLAG_MSB_MASK) != 8'd0) ? PH_LITERAL : PH_REF1;
          end
          PH_LITERAL: begin
            cmd_push_o = 1'b1;
            cmd_o.op   = OP_LIT;
            cmd_o.lit  = b;
            cmd_o.len  = 9'd1;
            flag_d     = fl_n;
            left_d     = left_n;
            ph_d       = ph_n;
          end
          PH_REF1: begin
            rf_d = b;
            ph_d = PH_REF2;
          end
          PH_REF2: begin
            dist_d = {rf_q[3:0] & DIST_HI_MASK, b};
            if (rf_q[7:4] == 4'd0) begin
              ph_d = PH_REF3;
            end else begin
              cmd_push_o      = 1'b1;
              cmd_o.op        = OP_COPY;
              cmd_o.back_dist = {rf_q[3:0] & DIST_HI_MASK, b};
              cmd_o.len       = {5'd0, rf_q[7:4]} + 9'd2;
              flag_d          = fl_n;
              left_d          = left_n;
              ph_d            = ph_n;
            end
          end
          PH_REF3: begin
            cmd_push_o      = 1'b1;
            cmd_o.op        = OP_COPY;
            cmd_o.back_dist = dist_q;
            cmd_o.len       = {1'b0, b} + LONG_LEN_BASE;
            flag_d          = fl_n;
            left_d          = left_n;
            ph_d            = ph_n;
          end
          default: begin
            ph_d = PH_HEADER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HEADER;
      hidx_q <= '0;
      dlen_q <= '0;
      flag_q <= '0;
      left_q <= '0;
      rf_q   <= '0;
      dist_q <= '0;
      stop_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      hidx_q <= hidx_d;
      dlen_q <= dlen_d;
      flag_q <= flag_d;
      left_q <= left_d;
      rf_q   <= rf_d;
      dist_q <= dist_d;
      stop_q <= stop_d;
    end
  end

endmodule

@@ rtl/yzd_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// Yaz0 decoder command queue
// Short queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yzd_cmd_fifo
  import yzd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (FIFO_AW + 1)'(push_i) - (FIFO_AW + 1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !pop_i))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");

endmodule

@@ rtl/yzd_back.sv @@
// ----------------------------------------------------------------------------
// Yaz0 decoder back end
// Runs literals and copies through the history ring and packs output beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yzd_back
  import yzd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_pop_o,
  input  logic [23:0]   skip_offset_i,
  output logic          ready_o,
  yzd_out_if.source     out_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RD    = 2'd2;
  localparam logic [1:0] ST_WR    = 2'd3;

  localparam logic [HIST_AW-1:0] LAST_ADDR = HIST_AW'(WINDOW_BYTES - 1);

  logic [7:0]         hist_mem [WINDOW_BYTES];
  logic [7:0]         rd_q;

  logic [1:0]         st_q, st_d;
  logic [HIST_AW-1:0] clr_q, clr_d;
  cmd_t               cur_q, cur_d;
  logic [8:0]         rem_q, rem_d;
  logic [HIST_AW-1:0] src_q, src_d;
  logic [HIST_AW-1:0] pos_q, pos_d;
  logic [31:0]        dec_q, dec_d;
  logic [23:0]        emit_q, emit_d;
  logic [23:0]        tgt_q, tgt_d;
  logic               stop_q, stop_d;
  logic [63:0]        acc_q, acc_d;
  logic [LANE_CW-1:0] cnt_q, cnt_d;

  logic               ov_q, ov_d;
  logic [63:0]        od_q, od_d;
  logic [3:0]         oc_q, oc_d;
  logic               ol_q, ol_d;
  logic               ob_q, ob_d;
  logic [23:0]        ot_q, ot_d;

  logic               wr_en, rd_en;
  logic [HIST_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               out_free;

  assign out_free = !ov_q || out_o.ready;
  assign ready_o  = (st_q != ST_CLEAR);

  assign out_o.valid         = ov_q;
  assign out_o.out_data      = od_q;
  assign out_o.byte_count    = oc_q;
  assign out_o.is_last       = ol_q;
  assign out_o.bad_magic     = ob_q;
  assign out_o.total_emitted = ot_q;

  always_comb begin
    logic [HIST_AW:0]   back;
    logic [7:0]         b;
    logic               emit;
    logic [63:0]        acc_n;
    logic [LANE_CW-1:0] cnt_n;
    logic [23:0]        emit_n;
    logic               hit;
    logic               end_c;

    st_d    = st_q;
    clr_d   = clr_q;
    cur_d   = cur_q;
    rem_d   = rem_q;
    src_d   = src_q;
    pos_d   = pos_q;
    dec_d   = dec_q;
    emit_d  = emit_q;
    tgt_d   = tgt_q;
    stop_d  = stop_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    ov_d    = out_o.ready ? 1'b0 : ov_q;
    od_d    = od_q;
    oc_d    = oc_q;
    ol_d    = ol_q;
    ob_d    = ob_q;
    ot_d    = ot_q;
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = 8'd0;
    rd_en   = 1'b0;
    cmd_pop_o = 1'b0;

    back   = {1'b0, HIST_AW'(cmd_i.back_dist)} + (HIST_AW + 1)'(1);
    b      = (cur_q.op == OP_LIT) ? cur_q.lit : rd_q;
    emit   = (dec_q >= {8'd0, skip_offset_i});
    acc_n  = acc_q;
    cnt_n  = cnt_q;
    emit_n = emit_q;
    if (emit) begin
      acc_n[cnt_q[LANE_IW-1:0]*8 +: 8] = b;
      cnt_n  = cnt_q + 1'b1;
      emit_n = emit_q + 24'd1;
    end
    hit   = emit && (emit_n == tgt_q);
    end_c = (rem_q == 9'd1);

    case (st_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_LIT, OP_COPY: begin
              cmd_pop_o = 1'b1;
              if (!stop_q) begin
                cur_d = cmd_i;
                rem_d = cmd_i.len;
                if ({1'b0, pos_q} >= back) begin
                  src_d = HIST_AW'({1'b0, pos_q} - back);
                end else begin
                  src_d = HIST_AW'({1'b0, pos_q} + (HIST_AW + 1)'(WINDOW_BYTES) - back);
                end
                st_d = (cmd_i.op == OP_COPY) ? ST_RD : ST_WR;
              end
            end
            OP_HDR, OP_BAD: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                pos_d  = '0;
                dec_d  = '0;
                emit_d = '0;
                acc_d  = '0;
                cnt_d  = '0;
                tgt_d  = cmd_i.target;
                stop_d = (cmd_i.op == OP_BAD) || (cmd_i.target == 24'd0);
                if (stop_d) begin
                  ov_d = 1'b1;
                  od_d = '0;
                  oc_d = '0;
                  ol_d = 1'b1;
                  ob_d = (cmd_i.op == OP_BAD);
                  ot_d = '0;
                end
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        src_d = (src_q == LAST_ADDR) ? '0 : src_q + 1'b1;
        st_d  = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = b;
          pos_d   = (pos_q == LAST_ADDR) ? '0 : pos_q + 1'b1;
          dec_d   = (dec_q == 32'hffff_ffff) ? dec_q : dec_q + 32'd1;
          emit_d  = emit_n;
          acc_d   = acc_n;
          cnt_d   = cnt_n;
          rem_d   = rem_q - 9'd1;
          // A beat leaves when the lanes fill, the target is hit, or the command ends.
          if (hit || cnt_n == LANE_CW'(OUT_LANES) || (end_c && cnt_n != '0)) begin
            ov_d  = 1'b1;
            od_d  = acc_n;
            oc_d  = 4'(cnt_n);
            ol_d  = hit;
            ob_d  = 1'b0;
            ot_d  = emit_n;
            acc_d = '0;
            cnt_d = '0;
          end
          if (hit) begin
            stop_d = 1'b1;
            st_d   = ST_IDLE;
          end else if (end_c) begin
            st_d = ST_IDLE;
          end else begin
            st_d = ST_RD;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= hist_mem[src_q];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rem_q <= rem_d;
    src_q <= src_d;
    od_q  <= od_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
    ob_q  <= ob_d;
    ot_q  <= ot_d;
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_CLEAR;
      clr_q  <= '0;
      pos_q  <= '0;
      dec_q  <= '0;
      emit_q <= '0;
      tgt_q  <= '0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      pos_q  <= pos_d;
      dec_q  <= dec_d;
      emit_q <= emit_d;
      tgt_q  <= tgt_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  a_lanes_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("partial lanes left over between commands");

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ob_q) |-> (ol_q && oc_q == 4'd0))
    else $error("bad magic beat must be final and empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oc_q <= 4'(OUT_LANES)))
    else $error("byte count exceeds lane count");

  a_stop_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> stop_q)
    else $error("engine not stopped while final beat waits");

endmodule

@@ rtl/yaz0_window_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Yaz0 window decoder unit
// Streaming Yaz0 decompressor with a 4096-byte history ring.
//
//   channel   dir  payload                                          beat
//   in_i      in   in_byte, stream_start                            one compressed byte
//   out_o     out  out_data, byte_count, is_last, bad_magic,        up to 8 decoded bytes
//                  total_emitted
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                  one register write
//
// The parser takes header, flag and reference bytes while the command queue has room.
// A literal goes through the copy engine as a command pop, then a write; a
// back-reference, after the pop, takes each byte as a registered history read,
// then a write; writes wait while the output register is full and not taken.
// After reset the history ring is cleared entry by entry; no input is taken then.
// A four-entry command queue lets the parser run ahead while the engine copies or
// the output side stalls; the output register holds a beat until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yaz0_window_decoder_unit
  import yzd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  yzd_in_if.sink      in_i,
  yzd_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  logic [23:0] skip_q;
  logic [23:0] max_q;

  logic cmd_push, cmd_full, cmd_pop, cmd_valid, back_ready;
  cmd_t cmd_in, cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 24'd0;
      max_q  <= 24'hff_ffff;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SKIP_OFFSET: skip_q <= cfg_data_i;
        REG_MAX_OUT:     max_q  <= cfg_data_i;
        default:         max_q  <= max_q;
      endcase
    end
  end

  yzd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .skip_offset_i (skip_q),
    .max_out_i     (max_q),
    .enable_i      (back_ready),
    .cmd_full_i    (cmd_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in)
  );

  yzd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  yzd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (cmd_pop),
    .skip_offset_i (skip_q),
    .ready_o       (back_ready),
    .out_o         (out_o)
  );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Yaz0 window decoder unit testbench
// Feeds compressed Yaz0 streams byte by byte and predicts every output beat
// with a behavioral decoder. Each beat is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import yzd_pkg::*;

  localparam int IDLE_PCT   = 10;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 3000;
  localparam int RANDOM_BYTES = 50;
  localparam logic [7:0] MAGIC [4] = '{8'h59, 8'h61, 8'h7a, 8'h30};

  typedef enum logic [2:0] {
    PH_HDR, PH_FLAG, PH_LIT, PH_REF1, PH_REF2, PH_REF3
  } parse_e;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  byte_count;
    logic        is_last;
    logic        bad_magic;
    logic [23:0] total_emitted;
  } beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [23:0] cfg_data_i;

  yzd_in_if  in_if ();
  yzd_out_if out_if ();

  yaz0_window_decoder_unit u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Expected output beats, oldest first.
  beat_t expected_beats[$];
  int    err_cnt;
  int    bytes_sent;
  bit    idle_en;
  int    hold_req;

  // Decoder model state.
  logic [23:0] skip_reg, max_reg;
  parse_e      ph;
  int          hdr_idx;
  logic [31:0] decl_len;
  logic [7:0]  flag_bits;
  int          flags_left;
  logic [7:0]  ref_hi;
  logic [11:0] ref_dist;
  logic [7:0]  hist [WINDOW_BYTES];
  logic [11:0] hist_pos;
  logic [31:0] decoded_cnt;
  logic [23:0] emitted_cnt;
  logic [23:0] out_target;
  bit          done;
  logic [63:0] lane_acc;
  int          lane_cnt;

  // Stream under construction.
  logic [7:0] stream_bytes[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_beat(logic [63:0] d, int cnt, bit last, bit bad);
    expected_beats.push_back('{d, cnt[3:0], last, bad, emitted_cnt});
  endfunction

  function automatic void flush_lanes(bit last);
    push_beat(lane_acc, lane_cnt, last, 1'b0);
    lane_acc = '0;
    lane_cnt = 0;
  endfunction

  function automatic void restart_model();
    ph          = PH_HDR;
    hdr_idx     = 0;
    decl_len    = '0;
    flag_bits   = '0;
    flags_left  = 0;
    ref_hi      = '0;
    ref_dist    = '0;
    hist_pos    = '0;
    decoded_cnt = '0;
    emitted_cnt = '0;
    out_target  = '0;
    done        = 1'b0;
  endfunction

  // Returns 1 once the output target is reached.
  function automatic bit take_decoded(logic [7:0] b);
    bit emit;
    emit = decoded_cnt >= {8'h00, skip_reg};
    hist[hist_pos] = b;
    hist_pos++;
    if (decoded_cnt != 32'hffff_ffff) decoded_cnt++;
    if (!emit) return 1'b0;
    lane_acc |= 64'(b) << (8 * lane_cnt);
    lane_cnt++;
    emitted_cnt++;
    if (emitted_cnt == out_target) begin
      flush_lanes(1'b1);
      done = 1'b1;
      return 1'b1;
    end
    if (lane_cnt >= OUT_LANES) flush_lanes(1'b0);
    return 1'b0;
  endfunction

  function automatic void copy_history(logic [11:0] back_dist, int len);
    logic [11:0] src;
    src = hist_pos - back_dist - 12'd1;
    for (int i = 0; i < len; i++) begin
      if (take_decoded(hist[src])) return;
      src++;
    end
  endfunction

  function automatic void advance_flag();
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left--;
    if (flags_left == 0) ph = PH_FLAG;
    else ph = flag_bits[7] ? PH_LIT : PH_REF1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, bit start);
    logic [31:0] avail;
    lane_acc = '0;
    lane_cnt = 0;
    if (start) restart_model();
    if (done) return;
    case (ph)
      PH_HDR: begin
        if (hdr_idx < 4) begin
          if (b != MAGIC[hdr_idx]) begin
            push_beat('0, 0, 1'b1, 1'b1);
            done = 1'b1;
            return;
          end
        end else if (hdr_idx < 8) begin
          decl_len = {decl_len[23:0], b};
        end
        hdr_idx++;
        if (hdr_idx >= HEADER_BYTES) begin
          avail = (decl_len > {8'h00, skip_reg}) ? decl_len - skip_reg : '0;
          out_target = (avail < {8'h00, max_reg}) ? avail[23:0] : max_reg;
          ph = PH_FLAG;
          if (out_target == '0) begin
            push_beat('0, 0, 1'b1, 1'b0);
            done = 1'b1;
          end
        end
        return;
      end
      PH_FLAG: begin
        flag_bits  = b;
        flags_left = 8;
        ph = (b & FLAG_MSB_MASK) ? PH_LIT : PH_REF1;
        return;
      end
      PH_LIT: begin
        if (!take_decoded(b)) advance_flag();
      end
      PH_REF1: begin
        ref_hi = b;
        ph = PH_REF2;
        return;
      end
      PH_REF2: begin
        ref_dist = {ref_hi[3:0] & DIST_HI_MASK, b};
        if (ref_hi[7:4] == 4'h0) begin
          ph = PH_REF3;
          return;
        end
        copy_history(ref_dist, int'(ref_hi[7:4]) + 2);
        if (!done) advance_flag();
      end
      default: begin
        copy_history(ref_dist, int'(b) + int'(LONG_LEN_BASE));
        if (!done) advance_flag();
      end
    endcase
    if (lane_cnt > 0) flush_lanes(1'b0);
  endfunction

  // Sends one compressed byte and predicts its beats once it is accepted.
  // Valid stays high after the beat; the next byte or an idle cycle replaces it.
  task automatic send_byte(logic [7:0] b, bit start);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.in_byte      <= b;
    in_if.stream_start <= start;
    do @(posedge clk_i); while (!in_if.ready);
    decode_byte(b, start);
    bytes_sent++;
  endtask

  task automatic send_stream(bit marked);
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], marked && i == 0);
    stream_bytes.delete();
  endtask

  task automatic add_header(logic [31:0] len);
    foreach (MAGIC[i]) stream_bytes.push_back(MAGIC[i]);
    for (int i = 3; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
    repeat (8) stream_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Random flag groups; copies are mostly short and near.
  task automatic add_body(int groups);
    logic [7:0]  flag;
    logic [3:0]  nib;
    logic [11:0] back_dist;
    repeat (groups) begin
      flag = 8'($urandom_range(255));
      stream_bytes.push_back(flag);
      for (int k = 7; k >= 0; k--) begin
        if (flag[k]) begin
          stream_bytes.push_back(8'($urandom_range(255)));
        end else begin
          nib       = 4'($urandom_range(15));
          back_dist = 12'(($urandom_range(3) != 0) ? $urandom_range(15)
                                                   : $urandom_range(4095));
          stream_bytes.push_back({nib, back_dist[11:8]});
          stream_bytes.push_back(back_dist[7:0]);
          if (nib == 4'h0)
            stream_bytes.push_back(8'(($urandom_range(7) != 0) ? $urandom_range(20)
                                                               : $urandom_range(255)));
        end
      end
    end
  endtask

  // Waits until every expected beat has arrived and the engine is quiet.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [23:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SKIP_OFFSET) skip_reg = val;
    else max_reg = val;
  endtask

  task automatic test_no_marker();
    add_header(32'd20);
    stream_bytes.push_back(8'hff);
    repeat (8) stream_bytes.push_back(8'($urandom_range(255)));
    send_stream(1'b0);
  endtask

  task automatic test_literal_extremes();
    add_header(32'd16);
    stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h55);
    stream_bytes.push_back(8'haa);
    repeat (4) stream_bytes.push_back(8'($urandom_range(255)));
    stream_bytes.push_back(8'hff);
    repeat (8) stream_bytes.push_back(8'($urandom_range(255)));
    send_stream(1'b1);
  endtask

  // Shortest, longest nibble and both extra-byte extremes, near and far.
  // The target is reached in the middle of the longest copy, not the last one.
  task automatic test_back_refs();
    add_header(32'd300);
    stream_bytes.push_back(8'h80);
    stream_bytes.push_back(8'hab);
    stream_bytes.push_back(8'h10); stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hf0); stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h0f); stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00); stream_bytes.push_back(8'h01);
    stream_bytes.push_back(8'hff);
    stream_bytes.push_back(8'h20); stream_bytes.push_back(8'h05);
    stream_bytes.push_back(8'h30); stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h40); stream_bytes.push_back(8'h02);
    send_stream(1'b1);
  endtask

  task automatic test_bad_magic();
    for (int k = 0; k < 4; k++) begin
      foreach (MAGIC[i]) stream_bytes.push_back((i == k) ? MAGIC[i] ^ 8'h01 : MAGIC[i]);
      repeat (3) stream_bytes.push_back(8'($urandom_range(255)));
      send_stream(1'b1);
    end
  endtask

  task automatic test_zero_target();
    add_header(32'd0);
    repeat (3) stream_bytes.push_back(8'($urandom_range(255)));
    send_stream(1'b1);
  endtask

  // A stream cut short by a new start marker.
  task automatic test_restart();
    add_header(32'd100);
    add_body(2);
    while (stream_bytes.size() > 22) void'(stream_bytes.pop_back());
    send_stream(1'b1);
    add_header(32'd12);
    add_body(1);
    send_stream(1'b1);
  endtask

  task automatic test_skip_and_limit();
    write_reg(REG_SKIP_OFFSET, 24'd5);
    write_reg(REG_MAX_OUT, 24'd11);
    add_header(32'd40);
    add_body(2);
    send_stream(1'b1);
    write_reg(REG_SKIP_OFFSET, 24'hffffff);
    add_header(32'hffff_ffff);
    add_body(1);
    send_stream(1'b1);
    write_reg(REG_SKIP_OFFSET, 24'd0);
    write_reg(REG_MAX_OUT, 24'd0);
    add_header(32'd9);
    send_stream(1'b1);
    write_reg(REG_MAX_OUT, 24'hffffff);
  endtask

  task automatic test_output_stall();
    hold_req = 400;
    add_header(32'd200);
    repeat (4) begin
      stream_bytes.push_back(8'hff);
      repeat (8) stream_bytes.push_back(8'($urandom_range(255)));
    end
    send_stream(1'b1);
  endtask

  task automatic test_random_streams();
    int start_cnt;
    int pick;
    start_cnt = bytes_sent;
    while (bytes_sent - start_cnt < RANDOM_BYTES) begin
      // A stretch in the middle runs with no idling on either side.
      idle_en = !(bytes_sent - start_cnt inside {[10:45]});
      pick = $urandom_range(99);
      if (pick < 75) begin
        add_header(($urandom_range(9) != 0) ? $urandom_range(60) : $urandom);
        add_body($urandom_range(1, 4));
        send_stream(1'b1);
      end else if (pick < 88) begin
        foreach (MAGIC[i]) stream_bytes.push_back(($urandom_range(3) == 0) ?
                                                  8'($urandom_range(255)) : MAGIC[i]);
        add_body(1);
        send_stream(1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) stream_bytes.push_back(8'($urandom_range(255)));
        send_stream($urandom_range(1));
      end
    end
    idle_en = 1'b1;
  endtask

  // Output side: random back-pressure plus a long hold requested by the stall test.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      out_if.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    beat_t exp_beat;
    if (out_if.valid && out_if.ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: out_data %h byte_count %0d", out_if.out_data,
               out_if.byte_count);
        err_cnt++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_if.out_data !== exp_beat.out_data) begin
          $error("out_data: expected %h, actual %h", exp_beat.out_data, out_if.out_data);
          err_cnt++;
        end
        if (out_if.byte_count !== exp_beat.byte_count) begin
          $error("byte_count: expected %0d, actual %0d", exp_beat.byte_count,
                 out_if.byte_count);
          err_cnt++;
        end
        if (out_if.is_last !== exp_beat.is_last) begin
          $error("is_last: expected %0d, actual %0d", exp_beat.is_last, out_if.is_last);
          err_cnt++;
        end
        if (out_if.bad_magic !== exp_beat.bad_magic) begin
          $error("bad_magic: expected %0d, actual %0d", exp_beat.bad_magic,
                 out_if.bad_magic);
          err_cnt++;
        end
        if (out_if.total_emitted !== exp_beat.total_emitted) begin
          $error("total_emitted: expected %0d, actual %0d", exp_beat.total_emitted,
                 out_if.total_emitted);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: no beats pass during the history clear after reset.
  int quiet_cycles;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_SKIP_OFFSET;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.stream_start  = 1'b0;
    out_if.ready        = 1'b0;
    err_cnt             = 0;
    bytes_sent          = 0;
    idle_en             = 1'b1;
    hold_req            = 0;
    quiet_cycles        = 0;
    skip_reg            = '0;
    max_reg             = 24'hffffff;
    foreach (hist[i]) hist[i] = '0;
    restart_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_no_marker();
    test_literal_extremes();
    test_back_refs();
    test_bad_magic();
    test_zero_target();
    test_restart();
    test_skip_and_limit();
    test_output_stall();
    test_random_streams();

    settle();
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
